[hw/rtl/bas_pkg.sv]
// Shared types and constants for the boid alignment step block.
// Holds the item structs, operation and register codes and the unit interface.
// No dependencies.
package bas_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_NEIGHBOURS = 1024;
  localparam int CNT_W          = $clog2(MAX_NEIGHBOURS + 1);

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Operation codes carried in the input item.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_NBR  = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FORCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NBR_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE = 3'd5;

  localparam logic [30:0]        RST_MAX_FORCE  = 31'd19661;
  localparam logic signed [31:0] RST_MIN_FORCE  = 32'sd0;
  localparam logic [30:0]        RST_MAX_SPEED  = 31'd32768;
  localparam logic [30:0]        RST_MIN_SPEED  = 31'd0;
  localparam logic [30:0]        RST_NBR_RADIUS = 31'd1310720;
  localparam logic [30:0]        RST_WORLD_SIZE = 31'd19660800;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_item_t;

  // Request to the iterative square root and divide unit.
  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [61:0] arg;
    logic [30:0] divisor;
  } sd_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] res;
  } sd_rsp_t;

endpackage

[hw/rtl/boid_alignment_step.sv]
// Boid alignment step: one 2D flocking agent in Q16.16, run by a small sequencer
// around a shared registered multiplier and a bit-serial square root and divide unit.
// A step runs up to three length scalings, each with a normalising shift loop and three
// root/divide passes. Reset clears the agent state and sums and returns the registers
// to their defaults.
module boid_alignment_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bas_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bas_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [bas_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [31:0]                          cfg_data_i
);
  import bas_pkg::*;

  // Sequencer states. The N states handle a neighbour sample, the S and D states
  // the step itself, C is the length clamp and K the scaling to a target length.
  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_N_DIFF  = 6'd1;
  localparam logic [5:0] ST_N_SQX   = 6'd2;
  localparam logic [5:0] ST_N_SQY   = 6'd3;
  localparam logic [5:0] ST_N_SQR   = 6'd4;
  localparam logic [5:0] ST_N_CMP   = 6'd5;
  localparam logic [5:0] ST_S_START = 6'd6;
  localparam logic [5:0] ST_S_DIFF  = 6'd7;
  localparam logic [5:0] ST_S_FORCE = 6'd8;
  localparam logic [5:0] ST_D_ABS   = 6'd9;
  localparam logic [5:0] ST_D_MX    = 6'd10;
  localparam logic [5:0] ST_D_MY    = 6'd11;
  localparam logic [5:0] ST_D_FY    = 6'd12;
  localparam logic [5:0] ST_D_ADD   = 6'd13;
  localparam logic [5:0] ST_S_POS   = 6'd14;
  localparam logic [5:0] ST_S_WRAP  = 6'd15;
  localparam logic [5:0] ST_C_0     = 6'd16;
  localparam logic [5:0] ST_C_SQA   = 6'd17;
  localparam logic [5:0] ST_C_SQB   = 6'd18;
  localparam logic [5:0] ST_C_MIN   = 6'd19;
  localparam logic [5:0] ST_C_MAX   = 6'd20;
  localparam logic [5:0] ST_C_DEC   = 6'd21;
  localparam logic [5:0] ST_K_0     = 6'd22;
  localparam logic [5:0] ST_K_NORM  = 6'd23;
  localparam logic [5:0] ST_K_SQA   = 6'd24;
  localparam logic [5:0] ST_K_SQB   = 6'd25;
  localparam logic [5:0] ST_K_SUM   = 6'd26;
  localparam logic [5:0] ST_K_SQRT  = 6'd27;
  localparam logic [5:0] ST_K_SQW   = 6'd28;
  localparam logic [5:0] ST_K_MX    = 6'd29;
  localparam logic [5:0] ST_K_DX    = 6'd30;
  localparam logic [5:0] ST_K_DXW   = 6'd31;
  localparam logic [5:0] ST_K_MY    = 6'd32;
  localparam logic [5:0] ST_K_DY    = 6'd33;
  localparam logic [5:0] ST_K_DYW   = 6'd34;

  localparam logic [30:0] UNIT_LEN = 31'(1) << FRAC_BITS;

  // Configuration registers.
  logic [30:0]        max_force_q, max_speed_q, min_speed_q, radius_q, world_q;
  logic signed [31:0] min_force_q;

  // Agent state.
  logic signed [31:0] own_px_q, own_py_q, own_vx_q, own_vy_q;
  logic signed [31:0] own_px_d, own_py_d, own_vx_d, own_vy_d;
  logic signed [43:0] sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Sequencer and working registers.
  logic [5:0]         state_q, state_d, ret_q, ret_d;
  in_item_t           in_q;
  logic signed [49:0] wx_q, wy_q, wx_d, wy_d;
  logic [48:0]        ma_q, mb_q, ma_d, mb_d;
  logic               sgnx_q, sgny_q, sgnx_d, sgny_d;
  logic [30:0]        target_q, target_d, len_q, len_d, qx_q, qx_d;
  logic [62:0]        acc_q, acc_d;
  logic [61:0]        mn2_q, mn2_d;
  logic signed [33:0] px_q, py_q, px_d, py_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               in_fire;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  sd_req_t            sd_req;
  sd_rsp_t            sd_rsp;

  // Helper arithmetic for the sequencer states.
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [48:0]        awx, awy, or_m;
  logic signed [49:0] max_f, min_f, fcx1, fcy1, fcx, fcy;
  logic               fs_sgn;
  logic signed [64:0] fs_p, fs_sh;
  logic signed [31:0] wpx, wpy;
  logic               out_free;

  function automatic logic signed [31:0] wrap_pos(input logic signed [33:0] p,
                                                  input logic [30:0] s);
    logic signed [34:0] t;
    logic signed [34:0] se;
    se = $signed({4'b0, s});
    if (p < 0) begin
      t = 35'(p) + se;
    end else if (35'(p) > se) begin
      t = 35'(p) - se;
    end else begin
      t = 35'(p);
    end
    if (t > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign dx  = 33'(own_px_q) - 33'(in_q.pos_x);
  assign dy  = 33'(own_py_q) - 33'(in_q.pos_y);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  assign awx  = wx_q[49] ? 49'(-wx_q) : wx_q[48:0];
  assign awy  = wy_q[49] ? 49'(-wy_q) : wy_q[48:0];
  assign or_m = ma_q | mb_q;

  // The upper force bound is applied first, so the lower one wins when they cross.
  assign max_f = $signed({19'b0, max_force_q});
  assign min_f = 50'(min_force_q);
  assign fcx1  = (wx_q > max_f) ? max_f : wx_q;
  assign fcy1  = (wy_q > max_f) ? max_f : wy_q;
  assign fcx   = (fcx1 < min_f) ? min_f : fcx1;
  assign fcy   = (fcy1 < min_f) ? min_f : fcy1;

  // Product by delta time, shifted down with rounding toward minus infinity.
  assign fs_sgn = (state_q == ST_D_MY) ? sgnx_q : sgny_q;
  assign fs_p   = fs_sgn ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
  assign fs_sh  = fs_p >>> FRAC_BITS;

  assign wpx = wrap_pos(px_q, world_q);
  assign wpy = wrap_pos(py_q, world_q);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    own_px_d    = own_px_q;
    own_py_d    = own_py_q;
    own_vx_d    = own_vx_q;
    own_vy_d    = own_vy_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    count_d     = count_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    sgnx_d      = sgnx_q;
    sgny_d      = sgny_q;
    target_d    = target_q;
    len_d       = len_q;
    qx_d        = qx_q;
    acc_d       = acc_q;
    mn2_d       = mn2_q;
    px_d        = px_q;
    py_d        = py_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    sd_req      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.op)
            OP_LOAD: begin
              own_px_d = in_data_i.pos_x;
              own_py_d = in_data_i.pos_y;
              own_vx_d = in_data_i.vel_x;
              own_vy_d = in_data_i.vel_y;
            end
            OP_NBR:  state_d = ST_N_DIFF;
            OP_STEP: state_d = ST_S_START;
            default: ;
          endcase
        end
      end

      // A neighbour with an offset of 2^31 or more is dropped at once.
      ST_N_DIFF: begin
        ma_d = 49'(adx);
        mb_d = 49'(ady);
        if (adx[32:31] != '0 || ady[32:31] != '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_N_SQX;
        end
      end
      ST_N_SQX: begin
        mul_a   = ma_q[31:0];
        mul_b   = ma_q[31:0];
        state_d = ST_N_SQY;
      end
      ST_N_SQY: begin
        acc_d   = mul_p[62:0];
        mul_a   = mb_q[31:0];
        mul_b   = mb_q[31:0];
        state_d = ST_N_SQR;
      end
      ST_N_SQR: begin
        acc_d   = acc_q + mul_p[62:0];
        mul_a   = {1'b0, radius_q};
        mul_b   = {1'b0, radius_q};
        state_d = ST_N_CMP;
      end
      ST_N_CMP: begin
        if (acc_q != '0 && acc_q < mul_p[62:0] &&
            count_q < CNT_W'(MAX_NEIGHBOURS)) begin
          sum_x_d = sum_x_q + 44'(in_q.vel_x);
          sum_y_d = sum_y_q + 44'(in_q.vel_y);
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_IDLE;
      end

      // Step: unit-scale the summed velocity, unless no neighbour counted.
      ST_S_START: begin
        if (count_q == '0) begin
          wx_d    = '0;
          wy_d    = '0;
          ret_d   = ST_D_ABS;
          state_d = ST_C_0;
        end else begin
          wx_d     = 50'(sum_x_q);
          wy_d     = 50'(sum_y_q);
          target_d = UNIT_LEN;
          ret_d    = ST_S_DIFF;
          state_d  = ST_K_0;
        end
      end
      ST_S_DIFF: begin
        wx_d    = wx_q - 50'(own_vx_q);
        wy_d    = wy_q - 50'(own_vy_q);
        state_d = ST_S_FORCE;
      end
      ST_S_FORCE: begin
        wx_d    = fcx;
        wy_d    = fcy;
        ret_d   = ST_D_ABS;
        state_d = ST_C_0;
      end

      // Acceleration times delta time, added to the own velocity.
      ST_D_ABS: begin
        ma_d    = awx;
        mb_d    = awy;
        sgnx_d  = wx_q[49];
        sgny_d  = wy_q[49];
        state_d = ST_D_MX;
      end
      ST_D_MX: begin
        mul_a   = ma_q[31:0];
        mul_b   = {1'b0, in_q.delta_time};
        state_d = ST_D_MY;
      end
      ST_D_MY: begin
        wx_d    = fs_sh[49:0];
        mul_a   = mb_q[31:0];
        mul_b   = {1'b0, in_q.delta_time};
        state_d = ST_D_FY;
      end
      ST_D_FY: begin
        wy_d    = fs_sh[49:0];
        state_d = ST_D_ADD;
      end
      ST_D_ADD: begin
        wx_d    = wx_q + 50'(own_vx_q);
        wy_d    = wy_q + 50'(own_vy_q);
        ret_d   = ST_S_POS;
        state_d = ST_C_0;
      end
      ST_S_POS: begin
        px_d    = 34'(own_px_q) + 34'($signed(wx_q[31:0]));
        py_d    = 34'(own_py_q) + 34'($signed(wy_q[31:0]));
        state_d = ST_S_WRAP;
      end
      ST_S_WRAP: begin
        if (out_free) begin
          out_d.new_pos_x = wpx;
          out_d.new_pos_y = wpy;
          out_d.new_vel_x = wx_q[31:0];
          out_d.new_vel_y = wy_q[31:0];
          out_valid_d     = 1'b1;
          own_px_d        = wpx;
          own_py_d        = wpy;
          own_vx_d        = wx_q[31:0];
          own_vy_d        = wy_q[31:0];
          sum_x_d         = '0;
          sum_y_d         = '0;
          count_d         = '0;
          state_d         = ST_IDLE;
        end
      end

      // Length clamp. A component of 2^31 or more counts as too long outright.
      ST_C_0: begin
        ma_d = awx;
        mb_d = awy;
        if (wx_q == '0 && wy_q == '0) begin
          state_d = ret_q;
        end else if (awx[48:31] != '0 || awy[48:31] != '0) begin
          target_d = max_speed_q;
          state_d  = ST_K_0;
        end else begin
          state_d = ST_C_SQA;
        end
      end
      ST_C_SQA: begin
        mul_a   = ma_q[31:0];
        mul_b   = ma_q[31:0];
        state_d = ST_C_SQB;
      end
      ST_C_SQB: begin
        acc_d   = mul_p[62:0];
        mul_a   = mb_q[31:0];
        mul_b   = mb_q[31:0];
        state_d = ST_C_MIN;
      end
      ST_C_MIN: begin
        acc_d   = acc_q + mul_p[62:0];
        mul_a   = {1'b0, min_speed_q};
        mul_b   = {1'b0, min_speed_q};
        state_d = ST_C_MAX;
      end
      ST_C_MAX: begin
        mn2_d   = mul_p[61:0];
        mul_a   = {1'b0, max_speed_q};
        mul_b   = {1'b0, max_speed_q};
        state_d = ST_C_DEC;
      end
      ST_C_DEC: begin
        if (acc_q < {1'b0, mn2_q}) begin
          target_d = min_speed_q;
          state_d  = ST_K_0;
        end else if (acc_q > mul_p[62:0]) begin
          target_d = max_speed_q;
          state_d  = ST_K_0;
        end else begin
          state_d = ret_q;
        end
      end

      // Scale the vector to the target length.
      ST_K_0: begin
        ma_d   = awx;
        mb_d   = awy;
        sgnx_d = wx_q[49];
        sgny_d = wy_q[49];
        if (wx_q == '0 && wy_q == '0) begin
          state_d = ret_q;
        end else begin
          state_d = ST_K_NORM;
        end
      end
      // One bit of shift a cycle until the larger magnitude sits in [2^29, 2^30).
      ST_K_NORM: begin
        if (or_m[48:30] != '0) begin
          ma_d = ma_q >> 1;
          mb_d = mb_q >> 1;
        end else if (!or_m[29]) begin
          ma_d = {ma_q[47:0], 1'b0};
          mb_d = {mb_q[47:0], 1'b0};
        end else begin
          state_d = ST_K_SQA;
        end
      end
      ST_K_SQA: begin
        mul_a   = ma_q[31:0];
        mul_b   = ma_q[31:0];
        state_d = ST_K_SQB;
      end
      ST_K_SQB: begin
        acc_d   = mul_p[62:0];
        mul_a   = mb_q[31:0];
        mul_b   = mb_q[31:0];
        state_d = ST_K_SUM;
      end
      ST_K_SUM: begin
        acc_d   = acc_q + mul_p[62:0];
        state_d = ST_K_SQRT;
      end
      ST_K_SQRT: begin
        sd_req.start = 1'b1;
        sd_req.sqrt  = 1'b1;
        sd_req.arg   = acc_q[61:0];
        state_d      = ST_K_SQW;
      end
      ST_K_SQW: begin
        if (sd_rsp.done) begin
          len_d   = sd_rsp.res;
          state_d = ST_K_MX;
        end
      end
      ST_K_MX: begin
        mul_a   = ma_q[31:0];
        mul_b   = {1'b0, target_q};
        state_d = ST_K_DX;
      end
      ST_K_DX: begin
        sd_req.start   = 1'b1;
        sd_req.arg     = mul_p[61:0];
        sd_req.divisor = len_q;
        state_d        = ST_K_DXW;
      end
      ST_K_DXW: begin
        if (sd_rsp.done) begin
          qx_d    = sd_rsp.res;
          state_d = ST_K_MY;
        end
      end
      ST_K_MY: begin
        mul_a   = mb_q[31:0];
        mul_b   = {1'b0, target_q};
        state_d = ST_K_DY;
      end
      ST_K_DY: begin
        sd_req.start   = 1'b1;
        sd_req.arg     = mul_p[61:0];
        sd_req.divisor = len_q;
        state_d        = ST_K_DYW;
      end
      ST_K_DYW: begin
        if (sd_rsp.done) begin
          wx_d    = sgnx_q ? -$signed({19'b0, qx_q}) : $signed({19'b0, qx_q});
          wy_d    = sgny_q ? -$signed({19'b0, sd_rsp.res}) : $signed({19'b0, sd_rsp.res});
          state_d = ret_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  bas_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bas_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sd_req),
    .rsp_o  (sd_rsp)
  );

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      out_valid_q <= 1'b0;
      own_px_q    <= '0;
      own_py_q    <= '0;
      own_vx_q    <= '0;
      own_vy_q    <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      own_px_q    <= own_px_d;
      own_py_q    <= own_py_d;
      own_vx_q    <= own_vx_d;
      own_vy_q    <= own_vy_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      count_q     <= count_d;
    end
  end

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_force_q <= RST_MAX_FORCE;
      min_force_q <= RST_MIN_FORCE;
      max_speed_q <= RST_MAX_SPEED;
      min_speed_q <= RST_MIN_SPEED;
      radius_q    <= RST_NBR_RADIUS;
      world_q     <= RST_WORLD_SIZE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_FORCE:  max_force_q <= cfg_data_i[30:0];
        CFG_MIN_FORCE:  min_force_q <= $signed(cfg_data_i);
        CFG_MAX_SPEED:  max_speed_q <= cfg_data_i[30:0];
        CFG_MIN_SPEED:  min_speed_q <= cfg_data_i[30:0];
        CFG_NBR_RADIUS: radius_q    <= cfg_data_i[30:0];
        CFG_WORLD_SIZE: world_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    wx_q     <= wx_d;
    wy_q     <= wy_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    sgnx_q   <= sgnx_d;
    sgny_q   <= sgny_d;
    target_q <= target_d;
    len_q    <= len_d;
    qx_q     <= qx_d;
    acc_q    <= acc_d;
    mn2_q    <= mn2_d;
    px_q     <= px_d;
    py_q     <= py_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_NEIGHBOURS))
    else $error("neighbour count beyond its limit");

  a_step_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_WRAP && out_free) |=>
      (out_valid_o && count_q == '0 && sum_x_q == '0 && sum_y_q == '0))
    else $error("step finished without result or without clearing the sums");

  a_unit_done_awaited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_rsp.done |-> (state_q == ST_K_SQW || state_q == ST_K_DXW || state_q == ST_K_DYW))
    else $error("root or divide result arrived while nobody waited");

  a_step_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.op == OP_STEP) |=> !in_ready_o)
    else $error("step transfer did not start the sequencer");

endmodule

[hw/rtl/bas_mul.sv]
// Registered unsigned multiplier shared by every product of the step.
// Depends on bas_pkg for the operand and product widths.
module bas_mul (
  input  logic                          clk_i,
  input  logic [bas_pkg::MUL_W-1:0]     a_i,
  input  logic [bas_pkg::MUL_W-1:0]     b_i,
  output logic [bas_pkg::PROD_W-1:0]    p_o
);
  import bas_pkg::*;

  logic [PROD_W-1:0] p_d, p_q;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/bas_sqdiv.sv]
// Iterative integer square root and restoring divider, one result bit a cycle.
// Depends on bas_pkg for the request and response structs.
module bas_sqdiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bas_pkg::sd_req_t req_i,
  output bas_pkg::sd_rsp_t rsp_o
);
  import bas_pkg::*;

  localparam int ITER = 31;

  logic        busy_q, done_q, mode_q;
  logic [4:0]  cnt_q;
  logic [61:0] n_q, r_q, bit_q;
  logic [30:0] rem_q, lo_q, dv_q;

  logic [61:0] sq_t;
  logic        sq_ge;
  logic [31:0] dv_t;
  logic        dv_ge;

  assign sq_t  = r_q + bit_q;
  assign sq_ge = n_q >= sq_t;
  assign dv_t  = {rem_q, lo_q[30]};
  assign dv_ge = dv_t >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(ITER - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.sqrt;
      n_q    <= req_i.arg;
      r_q    <= '0;
      bit_q  <= 62'd1 << 60;
      rem_q  <= {1'b0, req_i.arg[60:31]};
      lo_q   <= req_i.arg[30:0];
      dv_q   <= req_i.divisor;
    end else if (busy_q) begin
      if (mode_q) begin
        if (sq_ge) begin
          n_q <= n_q - sq_t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        if (dv_ge) begin
          rem_q <= 31'(dv_t - {1'b0, dv_q});
        end else begin
          rem_q <= dv_t[30:0];
        end
        lo_q <= {lo_q[29:0], dv_ge};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = mode_q ? r_q[30:0] : lo_q;

endmodule
